[hdl/tcw_pkg.sv]
// Shared constants and types for the text console character writer.
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Internal index widths follow from the geometry.
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   // Fixed field widths of the ports.
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = CHAR_W + COLOR_W;
   localparam int IN_COL_W   = 7;
   localparam int IN_ROW_W   = 5;
   localparam int POS_W      = 11;

   // Character and cell codes.
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
   localparam logic [CELL_W-1:0]  ZERO_CELL    = 16'h0000;
   localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;

   // Command codes.
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // One access to the screen memory.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] wdata;
   } ram_req_type;

endpackage

[hdl/tcw_addr.sv]
// Shared address unit: maps a screen row and column to a memory address.
module tcw_addr (
   input  logic [tcw_pkg::ROW_W-1:0]  top_row,
   input  logic [tcw_pkg::ROW_W-1:0]  row,
   input  logic [tcw_pkg::COL_W-1:0]  col,
   output logic [tcw_pkg::ADDR_W-1:0] addr
);
   import tcw_pkg::*;

   logic [ROW_W:0]   row_sum;
   logic [ROW_W-1:0] phys_row;

   // The rows form a ring; top_row is where screen row 0 lives.
   always_comb begin
      row_sum = {1'b0, top_row} + {1'b0, row};
      if (row_sum >= (ROW_W+1)'(ROWS)) begin
         phys_row = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
      end else begin
         phys_row = ROW_W'(row_sum);
      end
      addr = ADDR_W'(phys_row * COLUMNS) + ADDR_W'(col);
   end

endmodule

[hdl/tcw_ram.sv]
// Screen cell memory with one write port and a registered read port.
module tcw_ram (
   input  logic                       clock,
   input  tcw_pkg::ram_req_type       ram_req,
   output logic [tcw_pkg::CELL_W-1:0] rdata
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];

   // Write when asked, read the same address every cycle.
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      rdata <= mem[ram_req.addr];
   end

endmodule

[hdl/text_console_char_writer.sv]
// Top level of the text console character writer: sequencer, cursor and port logic.
// A put runs through EXEC to RESP, an in-range read through EXEC and RDWT to RESP.
// A put that scrolls also passes through CLEAR to clear the new bottom row.
// One word at a time: a new word is accepted only once the result of the last has been taken.
// Scrolling is a ring of rows, so only one row is ever cleared per scroll.
// Reset is synchronous; afterwards a clearing pass fills the screen with grey spaces
// while req_stall is held high.
module text_console_char_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::IN_COL_W-1:0]   req_read_col,
   input  logic [tcw_pkg::IN_ROW_W-1:0]   req_read_row,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]      rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]     rsp_read_entry,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::COLOR_W-1:0]    csr_text_color
);
   import tcw_pkg::*;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_RDWT  = 3'd3;
   localparam logic [2:0] S_CLEAR = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   init_cnt_ff, init_cnt_in;
   logic [COL_W-1:0]    clr_col_ff, clr_col_in;
   logic [ROW_W-1:0]    top_ff, top_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [COLOR_W-1:0]  color_ff;
   logic                cmd_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [IN_COL_W-1:0] rd_col_ff;
   logic [IN_ROW_W-1:0] rd_row_ff;
   logic [CELL_W-1:0]   entry_ff, entry_in;

   logic                req_accept;
   logic                is_newline;
   logic                rd_in_range;
   logic [ROW_W-1:0]    unit_row;
   logic [COL_W-1:0]    unit_col;
   logic [ADDR_W-1:0]   unit_addr;
   logic [ADDR_W-1:0]   pos_full;
   ram_req_type         ram_req;
   logic [CELL_W-1:0]   ram_rdata;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign csr_ready   = 1'b1;
   assign is_newline  = (char_ff == NEWLINE_CODE);
   assign rd_in_range = (int'(rd_col_ff) < COLUMNS) && (int'(rd_row_ff) < ROWS);

   // Cursor position is formed from the cursor registers, which hold during the result.
   assign pos_full            = ADDR_W'(cur_row_ff * COLUMNS) + ADDR_W'(cur_col_ff);
   assign rsp_cursor_position = POS_W'(pos_full);
   assign rsp_read_entry      = entry_ff;

   // The address unit serves puts, reads and the row clear.
   always_comb begin
      case (state_ff)
         S_EXEC: begin
            if (cmd_ff == CMD_READ) begin
               unit_row = ROW_W'(rd_row_ff);
               unit_col = COL_W'(rd_col_ff);
            end else begin
               unit_row = cur_row_ff;
               unit_col = cur_col_ff;
            end
         end
         S_CLEAR: begin
            unit_row = ROW_W'(ROWS - 1);
            unit_col = clr_col_ff;
         end
         default: begin
            unit_row = cur_row_ff;
            unit_col = cur_col_ff;
         end
      endcase
   end

   tcw_addr u_addr (
      .top_row (top_ff),
      .row     (unit_row),
      .col     (unit_col),
      .addr    (unit_addr)
   );

   // Memory access per state.
   always_comb begin
      ram_req.we    = 1'b0;
      ram_req.addr  = unit_addr;
      ram_req.wdata = {color_ff, char_ff};
      case (state_ff)
         S_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = init_cnt_ff;
            ram_req.wdata = BLANK_CELL;
         end
         S_EXEC: begin
            ram_req.we = (cmd_ff == CMD_PUT) && !is_newline;
         end
         S_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.wdata = ZERO_CELL;
         end
         default: begin
            ram_req.we = 1'b0;
         end
      endcase
   end

   tcw_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

   // Sequencer and cursor update.
   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      clr_col_in  = clr_col_ff;
      top_in      = top_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      entry_in    = entry_ff;
      case (state_ff)
         S_INIT: begin
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            entry_in = ZERO_CELL;
            if (cmd_ff == CMD_READ) begin
               state_in = rd_in_range ? S_RDWT : S_RESP;
            end else if (is_newline || cur_col_ff == COL_W'(COLUMNS - 1)) begin
               cur_col_in = '0;
               if (cur_row_ff == ROW_W'(ROWS - 1)) begin
                  // Scroll: the old top row becomes the new, cleared bottom row.
                  top_in     = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                  clr_col_in = '0;
                  state_in   = S_CLEAR;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
                  state_in   = S_RESP;
               end
            end else begin
               cur_col_in = cur_col_ff + 1'b1;
               state_in   = S_RESP;
            end
         end
         S_RDWT: begin
            entry_in = ram_rdata;
            state_in = S_RESP;
         end
         S_CLEAR: begin
            clr_col_in = clr_col_ff + 1'b1;
            if (clr_col_ff == COL_W'(COLUMNS - 1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         init_cnt_ff <= '0;
         clr_col_ff  <= '0;
         top_ff      <= '0;
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         color_ff    <= COLOR_RESET;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         clr_col_ff  <= clr_col_in;
         top_ff      <= top_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         if (csr_valid && csr_ready) begin
            color_ff <= csr_text_color;
         end
      end
   end

   // Payload registers for the accepted word and the result.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_command;
         char_ff   <= req_char_code;
         rd_col_ff <= req_read_col;
         rd_row_ff <= req_read_row;
      end
      entry_ff <= entry_in;
   end

   // The cursor and the ring pointer stay on the screen.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_col_ff) < COLUMNS)
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_row_ff) < ROWS && int'(top_ff) < ROWS)
      else $error("cursor row or top row out of range");

   // An accepted word is executed in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

   // A put never returns a cell.
   a_put_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cmd_ff == CMD_PUT) |-> rsp_read_entry == ZERO_CELL)
      else $error("put returned a nonzero cell");

   // The ring pointer only moves on a scroll.
   a_top_moves: assert property (@(posedge clock) disable iff (reset)
      (top_ff != $past(top_ff)) |-> $past(state_ff) == S_EXEC && state_ff == S_CLEAR)
      else $error("top row moved without a scroll");

endmodule

[test/testbench.sv]
// Self-checking testbench for the text console character writer.
`timescale 1ns / 100ps

module testbench;
   import tcw_pkg::*;

   // One expected result word: cursor position and the cell read back.
   typedef struct {
      logic [POS_W-1:0]  position;
      logic [CELL_W-1:0] entry;
   } console_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_command;
   logic [CHAR_W-1:0]   req_char_code;
   logic [IN_COL_W-1:0] req_read_col;
   logic [IN_ROW_W-1:0] req_read_row;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [POS_W-1:0]    rsp_cursor_position;
   logic [CELL_W-1:0]   rsp_read_entry;
   logic                csr_valid;
   logic                csr_ready;
   logic [COLOR_W-1:0]  csr_text_color;

   // Shadow copy of the screen, the cursor and the color register.
   logic [CELL_W-1:0]  screen_shadow [0:CELLS-1];
   int unsigned        cursor_row_now;
   int unsigned        cursor_col_now;
   logic [COLOR_W-1:0] color_now;

   console_result_type pending_results[$];
   int unsigned        error_count;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;

   text_console_char_writer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_char_code       (req_char_code),
      .req_read_col        (req_read_col),
      .req_read_row        (req_read_row),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_entry      (rsp_read_entry),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_color      (csr_text_color)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Move rows 1 and up by one row and blank the bottom row with zero cells.
   function automatic void scroll_screen_shadow();
      for (int i = 0; i < CELLS - COLUMNS; i++)
         screen_shadow[i] = screen_shadow[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen_shadow[i] = ZERO_CELL;
   endfunction

   // Apply one word to the shadow screen and work out the result it gives.
   function automatic console_result_type predict_console_word(
      input logic                cmd,
      input logic [CHAR_W-1:0]   code,
      input logic [IN_COL_W-1:0] col,
      input logic [IN_ROW_W-1:0] row
   );
      console_result_type r;
      int unsigned        pos;
      r.entry = ZERO_CELL;
      if (cmd == CMD_PUT) begin
         if (code != NEWLINE_CODE)
            screen_shadow[cursor_row_now * COLUMNS + cursor_col_now] = {color_now, code};
         cursor_col_now++;
         if (cursor_col_now >= COLUMNS || code == NEWLINE_CODE) begin
            cursor_col_now = 0;
            cursor_row_now++;
            if (cursor_row_now >= ROWS) begin
               scroll_screen_shadow();
               cursor_row_now = ROWS - 1;
            end
         end
      end else if (col < COLUMNS && row < ROWS) begin
         r.entry = screen_shadow[row * COLUMNS + col];
      end
      pos = cursor_row_now * COLUMNS + cursor_col_now;
      r.position = pos[POS_W-1:0];
      return r;
   endfunction

   // Send one word, with random idle cycles ahead of it, and record its result.
   task automatic send_word(
      input logic                cmd,
      input logic [CHAR_W-1:0]   code,
      input logic [IN_COL_W-1:0] col,
      input logic [IN_ROW_W-1:0] row
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_char_code <= code;
      req_read_col  <= col;
      req_read_row  <= row;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_console_word(cmd, code, col, row));
      @(negedge clock);
   endtask

   // Hold the input side off until every expected result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Write the color register while the block is idle.
   task automatic write_text_color(input logic [COLOR_W-1:0] color);
      wait_for_results();
      repeat (8) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_text_color <= color;
      do @(posedge clock); while (!csr_ready);
      color_now = color;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reads right after reset: grey spaces inside, zero outside the screen.
   task automatic test_reset_screen();
      send_word(CMD_READ, 8'h00, 7'd0, 5'd0);
      send_word(CMD_READ, 8'hFF, 7'd79, 5'd24);
      send_word(CMD_READ, 8'h00, 7'd80, 5'd0);
      send_word(CMD_READ, 8'hFF, 7'd127, 5'd31);
      send_word(CMD_READ, 8'h00, 7'd0, 5'd25);
      send_word(CMD_READ, 8'h55, 7'd40, 5'd12);
   endtask

   // Extreme character codes, a newline that stores nothing, and reads back.
   task automatic test_put_and_read();
      send_word(CMD_PUT, 8'h00, 7'd127, 5'd31);
      send_word(CMD_PUT, 8'hFF, 7'd0, 5'd0);
      send_word(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);
      send_word(CMD_PUT, 8'h41, 7'd0, 5'd0);
      send_word(CMD_READ, 8'h00, 7'd0, 5'd0);
      send_word(CMD_READ, 8'h00, 7'd1, 5'd0);
      send_word(CMD_READ, 8'h00, 7'd2, 5'd0);
      send_word(CMD_READ, 8'h00, 7'd0, 5'd1);
   endtask

   // The color register at both extremes, then back to its reset value.
   task automatic test_color_register();
      write_text_color(8'h00);
      send_word(CMD_PUT, 8'h5A, 7'd0, 5'd0);
      write_text_color(8'hFF);
      send_word(CMD_PUT, 8'h7A, 7'd0, 5'd0);
      send_word(CMD_READ, 8'h00, 7'd1, 5'd1);
      send_word(CMD_READ, 8'h00, 7'd2, 5'd1);
      write_text_color(COLOR_RESET);
   endtask

   // Bursts of text with a varying share of newlines, so that long lines wrap
   // and short lines scroll the screen, mixed with reads anywhere.
   task automatic test_console_traffic(input int unsigned count);
      int unsigned       left;
      int unsigned       burst;
      int unsigned       newline_pct;
      logic [CHAR_W-1:0] code;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(120, 10);
         if (burst > left)
            burst = left;
         case ($urandom_range(3))
            0: newline_pct = 0;
            1: newline_pct = 3;
            2: newline_pct = 25;
            default: newline_pct = 60;
         endcase
         for (int k = 0; k < burst; k++) begin
            if ($urandom_range(99) < 30) begin
               if ($urandom_range(99) < 85)
                  send_word(CMD_READ, CHAR_W'($urandom),
                            IN_COL_W'($urandom_range(COLUMNS - 1)),
                            IN_ROW_W'($urandom_range(ROWS - 1)));
               else
                  send_word(CMD_READ, CHAR_W'($urandom), IN_COL_W'($urandom_range(127)),
                            IN_ROW_W'($urandom_range(31)));
            end else begin
               code = CHAR_W'($urandom_range(255));
               if ($urandom_range(99) < newline_pct)
                  code = NEWLINE_CODE;
               send_word(CMD_PUT, code, IN_COL_W'($urandom_range(127)),
                         IN_ROW_W'($urandom_range(31)));
            end
         end
         left -= burst;
         // Now and then let the block run dry before going on.
         if ($urandom_range(9) == 0)
            wait_for_results();
      end
   endtask

   // Compare each result word with the oldest expected one.
   always @(posedge clock) begin : check_results
      console_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: cursor_position %0d, read_entry %h",
                   rsp_cursor_position, rsp_read_entry);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_cursor_position !== want.position) begin
               $error("cursor_position: expected %0d, actual %0d",
                      want.position, rsp_cursor_position);
               error_count++;
            end
            if (rsp_read_entry !== want.entry) begin
               $error("read_entry: expected %h, actual %h", want.entry, rsp_read_entry);
               error_count++;
            end
         end
      end
   end

   // Random stalls on the result side.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Watchdog.
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_PUT;
      req_char_code  = '0;
      req_read_col   = '0;
      req_read_row   = '0;
      csr_valid      = 1'b0;
      csr_text_color = '0;
      error_count    = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      for (int i = 0; i < CELLS; i++)
         screen_shadow[i] = BLANK_CELL;
      cursor_row_now = 0;
      cursor_col_now = 0;
      color_now      = COLOR_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_screen();
      test_put_and_read();
      test_color_register();

      // Four idling phases: none, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 75;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 75;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct     = 19;
            end
         endcase
         write_text_color(COLOR_W'($urandom_range(255)));
         test_console_traffic(430);
      end

      wait_for_results();
      repeat (100) @(negedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[text_console_char_writer.f]
hdl/tcw_pkg.sv
hdl/tcw_addr.sv
hdl/tcw_ram.sv
hdl/text_console_char_writer.sv
test/testbench.sv
